FILE: src/slhs_pkg.sv
// Shared types and constants of the sensor level hysteresis sampler.
package slhs_pkg;

    // Field widths fixed by the interface
    localparam int TEMP_W     = 12;
    localparam int HUM_W      = 10;
    localparam int PCT_W      = 7;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_EMPTY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_FULL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_AT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_AT     = 3'd4;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] RST_READ_INTERVAL = 16'd2500;
    localparam logic [PCT_W-1:0]      RST_EMPTY_AT      = 7'd5;
    localparam logic [PCT_W-1:0]      RST_REFILL_AT     = 7'd15;

    // Full scale of the percentage
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Quotient bits produced by the serial divider, one per cycle
    localparam int DIV_STEPS = PCT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, decide attempt
        logic mul;       // form numerator and denominator magnitudes
        logic chk;       // saturation check, divider setup
        logic div_step;  // one restoring division step
        logic commit;    // store percentage and empty flag
        logic out_load;  // load result register
    } slhs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic go;        // attempt with a valid climate reading
    } slhs_sts_t;

endpackage

FILE: src/slhs_ctrl.sv
// Controller state machine of the sensor level hysteresis sampler.
module slhs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  slhs_pkg::slhs_sts_t sts,
    output slhs_pkg::slhs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_UPD,
        ST_FIN
    } state_t;

    state_t                         state_reg, state_next;
    logic [slhs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           s_ready_reg, s_ready_next;
    logic                           m_valid_reg, m_valid_next;

    // Commands decoded from state
    always_comb begin
        cmd          = '0;
        cmd.load     = s_valid && s_ready_reg;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.chk      = (state_reg == ST_CHK);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.commit   = (state_reg == ST_UPD);
        cmd.out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = sts.go ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == slhs_pkg::DIV_CNT_W'(slhs_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (cmd.out_load) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs follow the next state
    always_comb begin
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: src/slhs_dp.sv
// Datapath of the sensor level hysteresis sampler: config, state, serial divider.
module slhs_dp #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr,
    input  logic [slhs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slhs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [TIME_BITS-1:0]                 now_ms,
    input  logic                                 climate_ok,
    input  logic signed [slhs_pkg::TEMP_W-1:0]   temperature_tenths,
    input  logic [slhs_pkg::HUM_W-1:0]           humidity_tenths,
    input  logic [ADC_BITS-1:0]                  level_raw,
    input  slhs_pkg::slhs_cmd_t                  cmd,
    output slhs_pkg::slhs_sts_t                  sts,
    output logic                                 attempted,
    output logic                                 sample_valid,
    output logic signed [slhs_pkg::TEMP_W-1:0]   held_temperature,
    output logic [slhs_pkg::HUM_W-1:0]           held_humidity,
    output logic [slhs_pkg::PCT_W-1:0]           level_percent,
    output logic                                 tank_empty,
    output logic [TIME_BITS-1:0]                 last_valid_ms
);

    localparam int PW = slhs_pkg::PCT_W;
    // numerator magnitude: raw difference times 100
    localparam int NW = ADC_BITS + PW;

    // Configuration registers
    logic [slhs_pkg::INTERVAL_W-1:0] interval_reg;
    logic [ADC_BITS-1:0]             raw_empty_reg, raw_full_reg;
    logic [PW-1:0]                   empty_at_reg, refill_at_reg;

    // Architectural state
    logic [TIME_BITS-1:0]             last_attempt_reg, valid_time_reg;
    logic signed [slhs_pkg::TEMP_W-1:0] temp_reg;
    logic [slhs_pkg::HUM_W-1:0]       hum_reg;
    logic [PW-1:0]                    percent_reg;
    logic                             empty_flag_reg;

    // Per-request working registers
    logic                attempt_reg, ok_reg;
    logic [ADC_BITS-1:0] raw_reg;
    logic [NW-1:0]       num_reg, rem_reg, den_sh_reg;
    logic [ADC_BITS-1:0] den_reg;
    logic                zero_reg, sat_reg;
    logic [PW-1:0]       q_reg;

    // Result register
    logic                               attempted_reg, sample_valid_reg, tank_empty_reg;
    logic signed [slhs_pkg::TEMP_W-1:0] out_temp_reg;
    logic [slhs_pkg::HUM_W-1:0]         out_hum_reg;
    logic [PW-1:0]                      out_pct_reg;
    logic [TIME_BITS-1:0]               out_time_reg;

    // Interval check on the incoming time stamp (wrapping difference)
    logic [TIME_BITS-1:0] elapsed;
    logic                 attempt_now;
    assign elapsed     = now_ms - last_attempt_reg;
    assign attempt_now = (elapsed >= TIME_BITS'(interval_reg));

    // Signed raw differences and their magnitudes
    logic [ADC_BITS:0]   diff_n, diff_d, neg_n, neg_d;
    logic [ADC_BITS-1:0] abs_n, abs_d;
    logic                zero_now;
    assign diff_n   = {1'b0, raw_reg} - {1'b0, raw_empty_reg};
    assign diff_d   = {1'b0, raw_full_reg} - {1'b0, raw_empty_reg};
    assign neg_n    = -diff_n;
    assign neg_d    = -diff_d;
    assign abs_n    = diff_n[ADC_BITS] ? neg_n[ADC_BITS-1:0] : diff_n[ADC_BITS-1:0];
    assign abs_d    = diff_d[ADC_BITS] ? neg_d[ADC_BITS-1:0] : diff_d[ADC_BITS-1:0];
    // zero span, zero offset, or a negative quotient all clamp to zero
    assign zero_now = (diff_d == '0) || (diff_n == '0) || (diff_n[ADC_BITS] != diff_d[ADC_BITS]);

    // Restoring division step
    logic          sub_ok;
    logic [NW-1:0] rem_sub;
    assign sub_ok  = (rem_reg >= den_sh_reg);
    assign rem_sub = rem_reg - den_sh_reg;

    // Final percentage and hysteresis
    logic [PW-1:0] pct_final;
    logic          flag_next;
    always_comb begin
        if (zero_reg) begin
            pct_final = '0;
        end else if (sat_reg || (q_reg > slhs_pkg::PCT_FULL)) begin
            pct_final = slhs_pkg::PCT_FULL;
        end else begin
            pct_final = q_reg;
        end
        flag_next = empty_flag_reg;
        if (!empty_flag_reg && (pct_final <= empty_at_reg)) begin
            flag_next = 1'b1;
        end else if (empty_flag_reg && (pct_final >= refill_at_reg)) begin
            flag_next = 1'b0;
        end
    end

    // Configuration and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg     <= slhs_pkg::RST_READ_INTERVAL;
            raw_empty_reg    <= '0;
            raw_full_reg     <= '1;
            empty_at_reg     <= slhs_pkg::RST_EMPTY_AT;
            refill_at_reg    <= slhs_pkg::RST_REFILL_AT;
            last_attempt_reg <= '0;
            valid_time_reg   <= '0;
            temp_reg         <= '0;
            hum_reg          <= '0;
            percent_reg      <= '0;
            empty_flag_reg   <= 1'b0;
            attempt_reg      <= 1'b0;
            ok_reg           <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    slhs_pkg::CFG_READ_INTERVAL: interval_reg  <= cfg_wdata;
                    slhs_pkg::CFG_RAW_EMPTY:     raw_empty_reg <= cfg_wdata[ADC_BITS-1:0];
                    slhs_pkg::CFG_RAW_FULL:      raw_full_reg  <= cfg_wdata[ADC_BITS-1:0];
                    slhs_pkg::CFG_EMPTY_AT:      empty_at_reg  <= cfg_wdata[PW-1:0];
                    slhs_pkg::CFG_REFILL_AT:     refill_at_reg <= cfg_wdata[PW-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                attempt_reg <= attempt_now;
                ok_reg      <= attempt_now && climate_ok;
                if (attempt_now) begin
                    last_attempt_reg <= now_ms;
                    if (climate_ok) begin
                        valid_time_reg <= now_ms;
                        temp_reg       <= temperature_tenths;
                        hum_reg        <= humidity_tenths;
                    end
                end
            end
            if (cmd.commit) begin
                percent_reg    <= pct_final;
                empty_flag_reg <= flag_next;
            end
        end
    end

    // Level mapping and serial divider, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_reg <= level_raw;
        end
        if (cmd.mul) begin
            num_reg  <= NW'(abs_n) * NW'(slhs_pkg::PCT_FULL);
            den_reg  <= abs_d;
            zero_reg <= zero_now;
        end
        if (cmd.chk) begin
            sat_reg    <= (num_reg >= {den_reg, {PW{1'b0}}});
            rem_reg    <= num_reg;
            den_sh_reg <= {1'b0, den_reg, {(PW-1){1'b0}}};
            q_reg      <= '0;
        end
        if (cmd.div_step) begin
            if (sub_ok) rem_reg <= rem_sub;
            q_reg      <= {q_reg[PW-2:0], sub_ok};
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            attempted_reg    <= attempt_reg;
            sample_valid_reg <= ok_reg;
            out_temp_reg     <= temp_reg;
            out_hum_reg      <= hum_reg;
            out_pct_reg      <= percent_reg;
            tank_empty_reg   <= empty_flag_reg;
            out_time_reg     <= valid_time_reg;
        end
    end

    assign sts.go           = ok_reg;
    assign attempted        = attempted_reg;
    assign sample_valid     = sample_valid_reg;
    assign held_temperature = out_temp_reg;
    assign held_humidity    = out_hum_reg;
    assign level_percent    = out_pct_reg;
    assign tank_empty       = tank_empty_reg;
    assign last_valid_ms    = out_time_reg;

endmodule

FILE: src/sensor_level_hysteresis_sampler_top.sv
// Top level of the sensor level hysteresis sampler.
//
//  channel | ports                       | carries
//  --------+-----------------------------+------------------------------------
//  cfg     | cfg_valid/cfg_ready         | register index and write data
//  s_      | s_valid/s_ready             | time stamp, climate reading, level
//  m_      | m_valid/m_ready             | attempt flags and held state
//
// A request with a sampling attempt and a valid climate reading passes from acceptance
// to the result register through evaluate, multiply, setup, seven serial divider
// steps (one quotient bit each), the state update and the result load. Other
// requests go from evaluate straight to the result load. s_ready rises the cycle
// after the result load. One request is in work at a time; a new one is taken
// while the previous result still waits in the output register, and the result
// load stalls while m_valid is high and m_ready is low.
// Reset is synchronous and active low; cfg_ready is always high.
module sensor_level_hysteresis_sampler_top #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slhs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slhs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [TIME_BITS-1:0]               s_now_ms,
    input  logic                               s_climate_ok,
    input  logic signed [slhs_pkg::TEMP_W-1:0] s_temperature_tenths,
    input  logic [slhs_pkg::HUM_W-1:0]         s_humidity_tenths,
    input  logic [ADC_BITS-1:0]                s_level_raw,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_attempted,
    output logic                               m_sample_valid,
    output logic signed [slhs_pkg::TEMP_W-1:0] m_held_temperature,
    output logic [slhs_pkg::HUM_W-1:0]         m_held_humidity,
    output logic [slhs_pkg::PCT_W-1:0]         m_level_percent,
    output logic                               m_tank_empty,
    output logic [TIME_BITS-1:0]               m_last_valid_ms
);

    slhs_pkg::slhs_cmd_t cmd;
    slhs_pkg::slhs_sts_t sts;

    assign cfg_ready = 1'b1;

    slhs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    slhs_dp #(
        .ADC_BITS  (ADC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .now_ms             (s_now_ms),
        .climate_ok         (s_climate_ok),
        .temperature_tenths (s_temperature_tenths),
        .humidity_tenths    (s_humidity_tenths),
        .level_raw          (s_level_raw),
        .cmd                (cmd),
        .sts                (sts),
        .attempted          (m_attempted),
        .sample_valid       (m_sample_valid),
        .held_temperature   (m_held_temperature),
        .held_humidity      (m_held_humidity),
        .level_percent      (m_level_percent),
        .tank_empty         (m_tank_empty),
        .last_valid_ms      (m_last_valid_ms)
    );

    // One request in work at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    // A valid sample implies an attempt
    a_valid_attempt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_attempted || !m_sample_valid))
        else $error("sample_valid without attempted");

    // Percentage stays clamped
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level_percent <= slhs_pkg::PCT_FULL))
        else $error("level percentage above full scale");

endmodule

FILE: sim/sampler_checker.sv
// Checker for the tank level sampler: tracks register writes, predicts each result, compares.
`timescale 1ns / 100ps

module sampler_checker
    import slhs_pkg::*;
#(
    parameter int ADC_W  = 12,
    parameter int TIME_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [TIME_W-1:0]     s_now_ms,
    input  logic                  s_climate_ok,
    input  logic [TEMP_W-1:0]     s_temperature_tenths,
    input  logic [HUM_W-1:0]      s_humidity_tenths,
    input  logic [ADC_W-1:0]      s_level_raw,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_attempted,
    input  logic                  m_sample_valid,
    input  logic signed [TEMP_W-1:0] m_held_temperature,
    input  logic [HUM_W-1:0]      m_held_humidity,
    input  logic [PCT_W-1:0]      m_level_percent,
    input  logic                  m_tank_empty,
    input  logic [TIME_W-1:0]     m_last_valid_ms,
    output int                    errors,
    output int                    awaiting
);

    typedef struct packed {
        logic              attempted;
        logic              sample_valid;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic [PCT_W-1:0]  pct;
        logic              empty;
        logic [TIME_W-1:0] valid_ms;
    } sampler_result_t;

    // Register copies
    logic [INTERVAL_W-1:0] read_interval;
    logic [ADC_W-1:0]      raw_empty;
    logic [ADC_W-1:0]      raw_full;
    logic [PCT_W-1:0]      empty_at;
    logic [PCT_W-1:0]      refill_at;

    // Sampler state
    logic [TIME_W-1:0] last_attempt_ms;
    logic [TIME_W-1:0] valid_time_ms;
    logic [TEMP_W-1:0] held_temp;
    logic [HUM_W-1:0]  held_hum;
    logic [PCT_W-1:0]  held_pct;
    logic              empty_flag;

    sampler_result_t readings_due[$];

    // Linear raw-to-percent map, truncating toward zero, clamped to 0..100
    function automatic logic [PCT_W-1:0] level_percent_of(input logic [ADC_W-1:0] raw);
        int lo, hi, x, p;
        lo = int'(raw_empty);
        hi = int'(raw_full);
        x  = int'(raw);
        if (hi == lo) return '0;
        p = ((x - lo) * 100) / (hi - lo);
        if (p < 0) p = 0;
        if (p > 100) p = 100;
        return PCT_W'(p);
    endfunction

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_READ_INTERVAL: read_interval = data[INTERVAL_W-1:0];
            CFG_RAW_EMPTY:     raw_empty     = data[ADC_W-1:0];
            CFG_RAW_FULL:      raw_full      = data[ADC_W-1:0];
            CFG_EMPTY_AT:      empty_at      = data[PCT_W-1:0];
            CFG_REFILL_AT:     refill_at     = data[PCT_W-1:0];
            default: ;
        endcase
    endtask

    // One request: attempt decision, climate capture, level map, hysteresis
    task automatic step_sampler(input logic [TIME_W-1:0] now, input logic ok,
                                input logic [TEMP_W-1:0] temp, input logic [HUM_W-1:0] hum,
                                input logic [ADC_W-1:0] raw);
        sampler_result_t r;
        logic [TIME_W-1:0] elapsed;
        elapsed = now - last_attempt_ms;
        r.attempted    = (elapsed >= TIME_W'(read_interval));
        r.sample_valid = r.attempted && ok;
        if (r.attempted) last_attempt_ms = now;
        if (r.sample_valid) begin
            held_temp     = temp;
            held_hum      = hum;
            valid_time_ms = now;
            held_pct      = level_percent_of(raw);
            if (!empty_flag && held_pct <= empty_at) empty_flag = 1'b1;
            else if (empty_flag && held_pct >= refill_at) empty_flag = 1'b0;
        end
        r.temp     = held_temp;
        r.hum      = held_hum;
        r.pct      = held_pct;
        r.empty    = empty_flag;
        r.valid_ms = valid_time_ms;
        readings_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        sampler_result_t want;
        if (!aresetn) begin
            read_interval   = RST_READ_INTERVAL;
            raw_empty       = '0;
            raw_full        = '1;
            empty_at        = RST_EMPTY_AT;
            refill_at       = RST_REFILL_AT;
            last_attempt_ms = '0;
            valid_time_ms   = '0;
            held_temp       = '0;
            held_hum        = '0;
            held_pct        = '0;
            empty_flag      = 1'b0;
            readings_due.delete();
            awaiting <= 0;
        end else begin
            if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                step_sampler(s_now_ms, s_climate_ok, s_temperature_tenths,
                             s_humidity_tenths, s_level_raw);
            // Compare each delivered result with the oldest prediction
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result delivered with no request outstanding");
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("attempted", want.attempted, m_attempted);
                    check_field("sample_valid", want.sample_valid, m_sample_valid);
                    check_field("held_temperature", $signed(want.temp), m_held_temperature);
                    check_field("held_humidity", want.hum, m_held_humidity);
                    check_field("level_percent", want.pct, m_level_percent);
                    check_field("tank_empty", want.empty, m_tank_empty);
                    check_field("last_valid_ms", want.valid_ms, m_last_valid_ms);
                end
            end
            awaiting <= readings_due.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the tank level sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import slhs_pkg::*;

    localparam int     ADC_W    = 12;
    localparam int     TIME_W   = 32;
    localparam int     PHASES   = 10;
    localparam int     PER_PHASE = 188;
    localparam int     DRAIN    = 32;
    localparam longint LIMIT_NS = 64'd8_000_000;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              ok;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic [ADC_W-1:0]  raw;
    } tank_sample_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [TIME_W-1:0]        s_now_ms = '0;
    logic                     s_climate_ok = 1'b0;
    logic signed [TEMP_W-1:0] s_temperature_tenths = '0;
    logic [HUM_W-1:0]         s_humidity_tenths = '0;
    logic [ADC_W-1:0]         s_level_raw = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic                     m_attempted;
    logic                     m_sample_valid;
    logic signed [TEMP_W-1:0] m_held_temperature;
    logic [HUM_W-1:0]         m_held_humidity;
    logic [PCT_W-1:0]         m_level_percent;
    logic                     m_tank_empty;
    logic [TIME_W-1:0]        m_last_valid_ms;
    int errors;
    int awaiting;

    sensor_level_hysteresis_sampler_top #(.ADC_BITS(ADC_W), .TIME_BITS(TIME_W)) dut (.*);
    sampler_checker #(.ADC_W(ADC_W), .TIME_W(TIME_W)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: ready pattern switches at random between four modes
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rx_phase % 23) < 3);
        endcase
    end

    // Stimulus shaping state
    int burst_left = 0;
    logic [TIME_W-1:0]     clock_ms = '0;
    logic [INTERVAL_W-1:0] interval_now = RST_READ_INTERVAL;
    logic [ADC_W-1:0]      span_a = '0;
    logic [ADC_W-1:0]      span_b = '1;

    function automatic tank_sample_t make_sample(input logic [TIME_W-1:0] now, input logic ok,
                                                 input int temp, input int hum, input int raw);
        tank_sample_t smp;
        smp.now  = now;
        smp.ok   = ok;
        smp.temp = TEMP_W'(temp);
        smp.hum  = HUM_W'(hum);
        smp.raw  = ADC_W'(raw);
        return smp;
    endfunction

    // Present one request and hold it until accepted
    task automatic push_sample(input tank_sample_t smp);
        s_valid              <= 1'b1;
        s_now_ms             <= smp.now;
        s_climate_ok         <= smp.ok;
        s_temperature_tenths <= smp.temp;
        s_humidity_tenths    <= smp.hum;
        s_level_raw          <= smp.raw;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Burst accounting; a gap of zero keeps valid high into the next request
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Stop sending and let every outstanding result drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Register settings per phase; later phases are random
    task automatic apply_setting(input int ph);
        logic [CFG_DATA_W-1:0] v [5];
        case (ph)
            1: v = '{16'd0, 16'd0, 16'd4095, 16'd0, 16'd100};
            2: v = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd100, 16'd0};
            3: v = '{16'd1000, 16'd2048, 16'd2048, 16'd10, 16'd20};
            4: v = '{16'd100, 16'd1000, 16'd3000, 16'd20, 16'd30};
            5: v = '{16'd50, 16'd0, 16'd4095, 16'hFFFF, 16'h007F};
            default: begin
                v[0] = CFG_DATA_W'($urandom_range(0, 3000));
                v[1] = CFG_DATA_W'($urandom);
                v[2] = CFG_DATA_W'($urandom);
                v[3] = CFG_DATA_W'($urandom_range(0, 100));
                v[4] = CFG_DATA_W'($urandom_range(0, 110));
            end
        endcase
        write_reg(CFG_READ_INTERVAL, v[0]);
        write_reg(CFG_RAW_EMPTY, v[1]);
        write_reg(CFG_RAW_FULL, v[2]);
        write_reg(CFG_EMPTY_AT, v[3]);
        write_reg(CFG_REFILL_AT, v[4]);
        // Writes to unmapped indexes must leave every register alone
        if (ph >= 6)
            write_reg(CFG_NO_REG - CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
        interval_now = v[0];
        span_a = v[1][ADC_W-1:0];
        span_b = v[2][ADC_W-1:0];
    endtask

    // Random request: mostly steps around the interval, some wraps and jumps
    function automatic tank_sample_t random_sample();
        int iv, t;
        logic [TIME_W-1:0] step;
        iv = int'(interval_now);
        case ($urandom_range(0, 19))
            0, 1, 2:  step = $urandom_range(0, iv);
            3, 4:     step = iv + $urandom_range(0, 1);
            5, 6:     step = $urandom;
            7:        step = 32'hFFFF_0000 + $urandom_range(0, 65535);
            default:  step = $urandom_range(iv / 2, iv * 2 + 8);
        endcase
        clock_ms = clock_ms + step;
        t = $urandom_range(0, 1650);
        t -= 400;
        return make_sample(clock_ms, $urandom_range(0, 6) != 0, t, $urandom_range(0, 1000),
                           ($urandom_range(0, 9) < 4) ? $urandom_range(0, 4095)
                                                      : $urandom_range(span_a, span_b));
    endfunction

    initial begin
        tank_sample_t directed [$];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: interval boundary, extremes, hysteresis edges, time wrap
        directed = '{
            make_sample(32'd0,     1'b1, 100,  500,  2000),  // no attempt right after reset
            make_sample(32'd2499,  1'b1, 100,  500,  2000),  // one short of the interval
            make_sample(32'd2500,  1'b1, -400, 0,    0),     // exactly the interval, sets empty
            make_sample(32'd5000,  1'b0, 55,   77,   4095),  // attempt with bad climate data
            make_sample(32'd7500,  1'b1, 1250, 1000, 4095),  // full tank clears empty
            make_sample(32'd10000, 1'b1, 0,    1,    204),   // 4 percent sets empty
            make_sample(32'd12500, 1'b1, -1,   512,  614),   // 14 percent holds the flag
            make_sample(32'd15000, 1'b1, 1024, 511,  615),   // 15 percent clears
            make_sample(32'd17500, 1'b1, 300,  700,  205),   // 5 percent sets again
            make_sample(32'hFFFF_FF00, 1'b1, 900, 333, 4000),
            make_sample(32'h0000_0100, 1'b1, 1, 2, 3),       // wrapped, too soon
            make_sample(32'd2243,  1'b1, 2, 3, 4),           // wrapped, one short
            make_sample(32'd2244,  1'b1, -399, 999, 1),      // wrapped, exactly the interval
            make_sample(32'h8000_0000, 1'b1, 1250, 1000, 3000)
        };
        foreach (directed[i]) begin
            push_sample(directed[i]);
            pace_sender();
        end
        clock_ms = 32'h8000_0000;

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph > 0) apply_setting(ph);
            for (int n = 0; n < PER_PHASE; n++) begin
                push_sample(random_sample());
                if ($urandom_range(0, 199) == 0) settle();
                else pace_sender();
            end
        end
        settle();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
